// ----- src/dpq_pkg.sv -----
`timescale 1ns / 1ps

package dpq_pkg;

   localparam int KEY_W = 32;
   localparam int ID_W  = 31;
   localparam int ENTRY_W = KEY_W + ID_W;

   // Request kinds carried in req_type.
   localparam logic [1:0] REQ_INSERT  = 2'd0;
   localparam logic [1:0] REQ_POP_MAX = 2'd1;
   localparam logic [1:0] REQ_POP_MIN = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         id;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0] popped_id;
      logic [1:0]      status;
   } result_type;

endpackage

// ----- src/dpq_if.sv -----
`timescale 1ns / 1ps

interface dpq_req_if;
   import dpq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic signed [KEY_W-1:0] entry_key;
   logic [ID_W-1:0]         entry_id;

   modport source (output valid, output req_type, output entry_key, output entry_id,
                   input ready);
   modport sink   (input valid, input req_type, input entry_key, input entry_id,
                   output ready);
endinterface

interface dpq_rsp_if;
   import dpq_pkg::*;

   logic            valid;
   logic            ready;
   logic [ID_W-1:0] popped_id;
   logic [1:0]      status;

   modport source (output valid, output popped_id, output status, input ready);
   modport sink   (input valid, input popped_id, input status, output ready);
endinterface

// ----- src/dpq_mem.sv -----
`timescale 1ns / 1ps

module dpq_mem
   import dpq_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data_ff
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- src/double_ended_priority_queue_top.sv -----
`timescale 1ns / 1ps
// Channel   | Dir | Beat contents
// req_chan  | in  | req_type, entry_key, entry_id
// rsp_chan  | out | popped_id, status (one beat per request)
//
// Entries sit sorted by key in a ring buffer in one single-port-read memory.
// A pop reads its entry in ST_POP_RD, takes it in ST_POP_WAIT and reports in ST_RESP;
// a refused insert or empty pop goes straight to ST_RESP. An insert runs a binary search
// for its insertion point, then shifts the tail up one entry at a time and writes the entry.
// Reset (synchronous) empties the queue at once; the memory needs no clearing.
// A finished result waits in the output register while the next request is accepted.

module double_ended_priority_queue_top
   import dpq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input logic clock,
   input logic reset,
   dpq_req_if.sink   req_chan,
   dpq_rsp_if.source rsp_chan
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_SHIFT_RD, ST_SHIFT_WR,
      ST_INS_WR, ST_POP_RD, ST_POP_WAIT, ST_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hi_ff, hi_in;
   logic [CW-1:0]           cur_ff, cur_in;
   logic [1:0]              kind_ff, kind_in;
   entry_type               new_ff, new_in;
   result_type              res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   logic [CW:0]             mid_sum;
   logic [CW-1:0]           mid;
   logic [CW-1:0]           ring_off;
   logic [AW:0]             ring_sum;
   logic [AW-1:0]           ring_addr;
   logic                    mem_wr_en;
   entry_type               mem_wr_data;
   logic                    mem_rd_en;
   entry_type               mem_rd_data;
   logic [CW-1:0]           lo_next, hi_next;
   logic                    accept;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.popped_id = rsp_ff.popped_id;
   assign rsp_chan.status = rsp_ff.status;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid = mid_sum[CW:1];

   // The one ring adder: a logical offset from the oldest (smallest) entry becomes a
   // physical address. Every memory access and the head advance go through it.
   always_comb begin
      unique case (state_ff)
         ST_SRCH_RD:  ring_off = mid;
         ST_SHIFT_RD: ring_off = cur_ff - CW'(1);
         ST_SHIFT_WR: ring_off = cur_ff;
         ST_INS_WR:   ring_off = lo_ff;
         ST_POP_RD:   ring_off = (kind_ff == REQ_POP_MAX) ? (count_ff - CW'(1)) : '0;
         ST_POP_WAIT: ring_off = CW'(1);
         default:     ring_off = '0;
      endcase
      ring_sum = {1'b0, head_ff} + (AW + 1)'(ring_off);
      if (ring_sum >= (AW + 1)'(CAPACITY)) begin
         ring_sum = ring_sum - (AW + 1)'(CAPACITY);
      end
      ring_addr = ring_sum[AW-1:0];
   end

   assign mem_rd_en = (state_ff == ST_SRCH_RD) || (state_ff == ST_SHIFT_RD) ||
                      (state_ff == ST_POP_RD);
   assign mem_wr_en = (state_ff == ST_SHIFT_WR) || (state_ff == ST_INS_WR);
   assign mem_wr_data = (state_ff == ST_SHIFT_WR) ? mem_rd_data : new_ff;

   dpq_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (ring_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (ring_addr),
      .rd_data_ff (mem_rd_data)
   );

   // Upper-bound search: equal keys keep arrival order, so the new entry goes after them.
   always_comb begin
      lo_next = lo_ff;
      hi_next = hi_ff;
      if (mem_rd_data.key <= new_ff.key) begin
         lo_next = mid + CW'(1);
      end else begin
         hi_next = mid;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      kind_in      = kind_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_chan.req_type;
               new_in.key = req_chan.entry_key;
               new_in.id  = req_chan.entry_id;
               res_in     = '{popped_id: '0, status: STATUS_OK};
               lo_in      = '0;
               hi_in      = count_ff;
               state_in   = ST_RESP;
               case (req_chan.req_type) inside
                  REQ_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_in.status = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_INS_WR;
                     end else begin
                        state_in = ST_SRCH_RD;
                     end
                  end
                  REQ_POP_MAX, REQ_POP_MIN: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_POP_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            lo_in  = lo_next;
            hi_in  = hi_next;
            cur_in = count_ff;
            if (lo_next != hi_next) begin
               state_in = ST_SRCH_RD;
            end else if (count_ff == lo_next) begin
               state_in = ST_INS_WR;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cur_in = cur_ff - CW'(1);
            state_in = ((cur_ff - CW'(1)) == lo_ff) ? ST_INS_WR : ST_SHIFT_RD;
         end
         ST_INS_WR: begin
            count_in = count_ff + CW'(1);
            state_in = ST_RESP;
         end
         ST_POP_RD: begin
            state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            res_in.popped_id = mem_rd_data.id;
            count_in = count_ff - CW'(1);
            if (kind_ff == REQ_POP_MIN) begin
               head_in = ring_addr;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      cur_ff  <= cur_in;
      kind_ff <= kind_in;
      new_ff  <= new_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff < AW'(CAPACITY - 1) || head_ff == AW'(CAPACITY - 1))
      else $error("ring head out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request accepted while previous one still in progress");

   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && rsp_in.status == STATUS_FULL) |->
      count_ff == CW'(CAPACITY))
      else $error("insert refused while space remains");

   a_shift_inside_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_WR) |-> (cur_ff > lo_ff && cur_ff <= count_ff))
      else $error("tail shift outside the occupied range");

endmodule
